// ===== hw/rtl/chsd_pkg.sv =====
// shared types and constants of the canonical huffman symbol decoder
`default_nettype none
package chsd_pkg;

    localparam int MAX_CODE_LEN_DEF = 16;
    localparam int SYM_W            = 9;
    localparam int SYM_DEPTH        = 512;
    localparam int SYM_AW           = 9;
    localparam int KIND_W           = 3;
    localparam int ERR_W            = 2;
    localparam int CFG_IDX_W        = 2;
    localparam int CTRL_BASE        = 256;

    localparam logic [1:0] CFG_FILENAME_END = 2'd0;
    localparam logic [1:0] CFG_MORE_FILES   = 2'd1;
    localparam logic [1:0] CFG_ARCHIVE_END  = 2'd2;

    localparam logic [SYM_W-1:0] FILENAME_END_RST = 9'd256;
    localparam logic [SYM_W-1:0] MORE_FILES_RST   = 9'd257;
    localparam logic [SYM_W-1:0] ARCHIVE_END_RST  = 9'd258;

    localparam logic [KIND_W-1:0] KIND_FILENAME_BYTE = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CONTENT_BYTE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FILENAME_END  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_MORE_FILES    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ARCHIVE_END   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_ERROR         = 3'd5;

    localparam logic [ERR_W-1:0] ERR_NONE        = 2'd0;
    localparam logic [ERR_W-1:0] ERR_BAD_HEADER  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_NOT_FOUND   = 2'd2;
    localparam logic [ERR_W-1:0] ERR_UNEXPECTED  = 2'd3;

    typedef enum logic [2:0] {
        PH_COUNT,
        PH_SYMBOLS,
        PH_LENGTHS,
        PH_DECODE,
        PH_WAIT,
        PH_DONE,
        PH_HALT
    } phase_t;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_LOOKUP,
        OP_ERROR
    } op_t;

    typedef enum logic [1:0] {
        ACT_CONTINUE,
        ACT_NEW_HEADER,
        ACT_DONE,
        ACT_HALT
    } act_t;

    typedef struct packed {
        op_t               op;
        logic [SYM_AW-1:0] addr;
        logic [SYM_W-1:0]  data;
        logic [ERR_W-1:0]  err;
    } cmd_t;

    typedef struct packed {
        logic valid;
        act_t act;
    } fb_t;

endpackage
`default_nettype wire

// ===== hw/rtl/canonical_huffman_symbol_decoder.sv =====
// top level of the canonical huffman symbol decoder
// usage:
//   input channel in_valid/in_ready/value: each word is a header word (symbol
//   count, symbols, per-length counts) or, once the header is complete, one
//   code bit in value[0], msb of each code first
//   output channel out_valid/out_ready/symbol/kind/error_code: one word per
//   completed code or per error; header words give no word unless in error
//   config port cfg_write_en/cfg_index/cfg_data sets the three control symbol
//   values; write only while the block is idle
// throughput: header words and code bits that do not complete a code are
//   taken one per cycle; a bit that completes a code keeps in_ready low
//   while the back end reads the symbol memory and decides whether
//   decoding goes on, a new header follows or the archive is over
// a completed code passes the queue, the symbol read and the output register
// reset: clears all control state and restores the default control symbols;
//   the symbol memory keeps no reset value and needs no clearing pass
// stall: a completed code waits for a free output register before decoding
//   goes on, so in_ready stays low until out_ready frees it
// after an error the block takes and drops all input until reset; after the
//   archive end symbol it does the same without an error
`default_nettype none
module canonical_huffman_symbol_decoder #(
    parameter int MAX_CODE_LEN = chsd_pkg::MAX_CODE_LEN_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [chsd_pkg::SYM_W-1:0]     value,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [chsd_pkg::SYM_W-1:0]          symbol,
    output logic [chsd_pkg::KIND_W-1:0]         kind,
    output logic [chsd_pkg::ERR_W-1:0]          error_code,
    input  wire logic                           cfg_write_en,
    input  wire logic [chsd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [chsd_pkg::SYM_W-1:0]     cfg_data
);
    logic           push, full, pop, avail;
    chsd_pkg::cmd_t push_cmd, pop_cmd;
    chsd_pkg::fb_t  fb;

    // front: header parsing and bitwise matching against the length tables
    chsd_front #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .cmd_valid (push),
        .cmd       (push_cmd),
        .cmd_full  (full),
        .fb        (fb)
    );

    // short queue so each side stalls on its own
    chsd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_cmd),
        .not_empty (avail)
    );

    // back: symbol store, classification, output word
    chsd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_avail    (avail),
        .cmd          (pop_cmd),
        .cmd_pop      (pop),
        .fb           (fb),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .symbol       (symbol),
        .kind         (kind),
        .error_code   (error_code)
    );
endmodule
`default_nettype wire

// ===== hw/rtl/chsd_fifo.sv =====
// two-entry command queue between front and back
`default_nettype none
module chsd_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire chsd_pkg::cmd_t push_data,
    output logic               full,
    input  wire logic          pop,
    output chsd_pkg::cmd_t     pop_data,
    output logic               not_empty
);
    chsd_pkg::cmd_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/chsd_front.sv =====
// front: header loading, code tables and bitwise code matching
`default_nettype none
module chsd_front #(
    parameter int MAX_CODE_LEN = chsd_pkg::MAX_CODE_LEN_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [chsd_pkg::SYM_W-1:0] value,
    output logic                          cmd_valid,
    output chsd_pkg::cmd_t                cmd,
    input  wire logic                     cmd_full,
    input  wire chsd_pkg::fb_t            fb
);
    localparam int LW = $clog2(MAX_CODE_LEN + 1);
    localparam int ML = MAX_CODE_LEN;

    chsd_pkg::phase_t phase_reg, phase_next;
    logic [8:0]    expected_reg, expected_next;
    logic [8:0]    loaded_reg, loaded_next;
    logic [8:0]    assigned_reg, assigned_next;
    logic [LW-1:0] hdr_len_reg, hdr_len_next;
    logic [ML:0]   next_code_reg, next_code_next;
    logic [LW-1:0] max_len_reg, max_len_next;
    logic [ML-1:0] last_code_reg, last_code_next;
    logic [ML-1:0] partial_reg, partial_next;
    logic [LW-1:0] part_len_reg, part_len_next;

    logic [ML:0]   first_tab [ML+1];
    logic [8:0]    count_tab [ML+1];
    logic [8:0]    base_tab  [ML+1];

    logic          fire, tab_we;
    logic [LW:0]   len;
    logic [9:0]    sum;
    logic [ML+1:0] start, limit;
    logic [ML-1:0] pc;
    logic [LW-1:0] dlen;
    logic [ML:0]   dfirst, off;
    logic [8:0]    dcount;
    logic          match, dead;

    assign in_ready = (phase_reg != chsd_pkg::PH_WAIT) && !cmd_full;
    assign fire     = in_valid && in_ready;

    // length-count arithmetic
    assign len   = {1'b0, hdr_len_reg} + (LW+1)'(1);
    assign sum   = {1'b0, assigned_reg} + {1'b0, value};
    assign start = {1'b0, next_code_reg} << 1;
    assign limit = (ML+2)'(1) << len;

    // one code bit
    assign pc     = {partial_reg[ML-2:0], value[0]};
    assign dlen   = part_len_reg + LW'(1);
    assign dfirst = first_tab[dlen];
    assign dcount = count_tab[dlen];
    assign off    = {1'b0, pc} - dfirst;
    assign match  = (dcount != 9'd0) && ({1'b0, pc} >= dfirst)
                    && (off < (ML+1)'(dcount));
    assign dead   = pc > (last_code_reg >> (max_len_reg - dlen));

    always_comb
    begin
        phase_next     = phase_reg;
        expected_next  = expected_reg;
        loaded_next    = loaded_reg;
        assigned_next  = assigned_reg;
        hdr_len_next   = hdr_len_reg;
        next_code_next = next_code_reg;
        max_len_next   = max_len_reg;
        last_code_next = last_code_reg;
        partial_next   = partial_reg;
        part_len_next  = part_len_reg;
        tab_we         = 1'b0;
        cmd_valid      = 1'b0;
        cmd.op         = chsd_pkg::OP_WRITE;
        cmd.addr       = loaded_reg;
        cmd.data       = value;
        cmd.err        = chsd_pkg::ERR_NONE;

        case (phase_reg)
            chsd_pkg::PH_COUNT:
            begin
                if (fire)
                begin
                    expected_next = value;
                    loaded_next   = 9'd0;
                    phase_next    = (value == 9'd0) ? chsd_pkg::PH_DECODE
                                                    : chsd_pkg::PH_SYMBOLS;
                end
            end
            chsd_pkg::PH_SYMBOLS:
            begin
                if (fire)
                begin
                    cmd_valid   = 1'b1;
                    loaded_next = loaded_reg + 9'd1;
                    if (({1'b0, loaded_reg} + 10'd1) >= {1'b0, expected_reg})
                    begin
                        phase_next = chsd_pkg::PH_LENGTHS;
                    end
                end
            end
            chsd_pkg::PH_LENGTHS:
            begin
                if (fire)
                begin
                    if ((len > (LW+1)'(ML)) || (sum > {1'b0, expected_reg})
                        || ((start + (ML+2)'(value)) > limit))
                    begin
                        cmd_valid  = 1'b1;
                        cmd.op     = chsd_pkg::OP_ERROR;
                        cmd.err    = chsd_pkg::ERR_BAD_HEADER;
                        phase_next = chsd_pkg::PH_HALT;
                    end
                    else
                    begin
                        tab_we         = 1'b1;
                        next_code_next = (ML+1)'(start + (ML+2)'(value));
                        assigned_next  = sum[8:0];
                        hdr_len_next   = len[LW-1:0];
                        if (sum == {1'b0, expected_reg})
                        begin
                            max_len_next   = len[LW-1:0];
                            last_code_next = ML'(start + (ML+2)'(value) - (ML+2)'(1));
                            phase_next     = chsd_pkg::PH_DECODE;
                        end
                        else if (len >= (LW+1)'(ML))
                        begin
                            cmd_valid  = 1'b1;
                            cmd.op     = chsd_pkg::OP_ERROR;
                            cmd.err    = chsd_pkg::ERR_BAD_HEADER;
                            phase_next = chsd_pkg::PH_HALT;
                        end
                    end
                end
            end
            chsd_pkg::PH_DECODE:
            begin
                if (fire)
                begin
                    if (part_len_reg >= max_len_reg)
                    begin
                        cmd_valid  = 1'b1;
                        cmd.op     = chsd_pkg::OP_ERROR;
                        cmd.err    = chsd_pkg::ERR_NOT_FOUND;
                        phase_next = chsd_pkg::PH_HALT;
                    end
                    else if (match)
                    begin
                        cmd_valid     = 1'b1;
                        cmd.op        = chsd_pkg::OP_LOOKUP;
                        cmd.addr      = base_tab[dlen] + off[8:0];
                        partial_next  = '0;
                        part_len_next = '0;
                        phase_next    = chsd_pkg::PH_WAIT;
                    end
                    else if (dead)
                    begin
                        cmd_valid  = 1'b1;
                        cmd.op     = chsd_pkg::OP_ERROR;
                        cmd.err    = chsd_pkg::ERR_NOT_FOUND;
                        phase_next = chsd_pkg::PH_HALT;
                    end
                    else
                    begin
                        partial_next  = pc;
                        part_len_next = dlen;
                    end
                end
            end
            chsd_pkg::PH_WAIT:
            begin
                if (fb.valid)
                begin
                    case (fb.act)
                        chsd_pkg::ACT_CONTINUE:   phase_next = chsd_pkg::PH_DECODE;
                        chsd_pkg::ACT_NEW_HEADER:
                        begin
                            phase_next     = chsd_pkg::PH_COUNT;
                            expected_next  = '0;
                            loaded_next    = '0;
                            assigned_next  = '0;
                            hdr_len_next   = '0;
                            next_code_next = '0;
                            max_len_next   = '0;
                            last_code_next = '0;
                        end
                        chsd_pkg::ACT_DONE:       phase_next = chsd_pkg::PH_DONE;
                        default:                  phase_next = chsd_pkg::PH_HALT;
                    endcase
                end
            end
            default:
            begin
                // done or halted: words are taken and dropped
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= chsd_pkg::PH_COUNT;
            expected_reg  <= '0;
            loaded_reg    <= '0;
            assigned_reg  <= '0;
            hdr_len_reg   <= '0;
            next_code_reg <= '0;
            max_len_reg   <= '0;
            last_code_reg <= '0;
            partial_reg   <= '0;
            part_len_reg  <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            expected_reg  <= expected_next;
            loaded_reg    <= loaded_next;
            assigned_reg  <= assigned_next;
            hdr_len_reg   <= hdr_len_next;
            next_code_reg <= next_code_next;
            max_len_reg   <= max_len_next;
            last_code_reg <= last_code_next;
            partial_reg   <= partial_next;
            part_len_reg  <= part_len_next;
        end
    end

    // per-length tables, each entry written before any bit reads it
    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            first_tab[len[LW-1:0]] <= start[ML:0];
            count_tab[len[LW-1:0]] <= value;
            base_tab[len[LW-1:0]]  <= assigned_reg;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/chsd_back.sv =====
// back: symbol memory, symbol classification and output register
`default_nettype none
module chsd_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cmd_avail,
    input  wire chsd_pkg::cmd_t                cmd,
    output logic                               cmd_pop,
    output chsd_pkg::fb_t                      fb,
    input  wire logic                          cfg_write_en,
    input  wire logic [chsd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [chsd_pkg::SYM_W-1:0]    cfg_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [chsd_pkg::SYM_W-1:0]         symbol,
    output logic [chsd_pkg::KIND_W-1:0]        kind,
    output logic [chsd_pkg::ERR_W-1:0]         error_code
);
    logic [chsd_pkg::SYM_W-1:0] mem [chsd_pkg::SYM_DEPTH];
    logic [chsd_pkg::SYM_W-1:0] rd_data_reg;
    logic [chsd_pkg::SYM_W-1:0] fe_reg, mf_reg, ae_reg;

    logic                       s1_valid_reg, s1_valid_next;
    logic                       s1_lookup_reg;
    logic [chsd_pkg::ERR_W-1:0] s1_err_reg;
    logic                       content_reg, content_next;
    logic                       out_valid_reg, out_valid_next;
    logic [chsd_pkg::SYM_W-1:0]  sym_reg, sym_next;
    logic [chsd_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic [chsd_pkg::ERR_W-1:0]  err_reg, err_next;

    logic s1_adv, s1_free, is_write, is_ctrl;

    assign out_valid  = out_valid_reg;
    assign symbol     = sym_reg;
    assign kind       = kind_reg;
    assign error_code = err_reg;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign s1_free  = !s1_valid_reg || s1_adv;
    assign is_write = (cmd.op == chsd_pkg::OP_WRITE);
    assign cmd_pop  = cmd_avail && (is_write || s1_free);
    assign is_ctrl  = rd_data_reg >= 9'(chsd_pkg::CTRL_BASE);

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        if (cmd_pop && !is_write)
        begin
            s1_valid_next = 1'b1;
        end

        out_valid_next = out_valid_reg && !out_ready;
        content_next   = content_reg;
        sym_next       = sym_reg;
        kind_next      = kind_reg;
        err_next       = err_reg;
        fb.valid       = 1'b0;
        fb.act         = chsd_pkg::ACT_CONTINUE;

        if (s1_adv)
        begin
            out_valid_next = 1'b1;
            if (!s1_lookup_reg)
            begin
                sym_next  = '0;
                kind_next = chsd_pkg::KIND_ERROR;
                err_next  = s1_err_reg;
            end
            else
            begin
                fb.valid  = 1'b1;
                sym_next  = rd_data_reg;
                err_next  = chsd_pkg::ERR_NONE;
                if (!content_reg)
                begin
                    if (rd_data_reg == fe_reg)
                    begin
                        kind_next    = chsd_pkg::KIND_FILENAME_END;
                        content_next = 1'b1;
                    end
                    else if (is_ctrl)
                    begin
                        fb.act = chsd_pkg::ACT_HALT;
                    end
                    else
                    begin
                        kind_next = chsd_pkg::KIND_FILENAME_BYTE;
                    end
                end
                else
                begin
                    if (rd_data_reg == mf_reg)
                    begin
                        kind_next    = chsd_pkg::KIND_MORE_FILES;
                        content_next = 1'b0;
                        fb.act       = chsd_pkg::ACT_NEW_HEADER;
                    end
                    else if (rd_data_reg == ae_reg)
                    begin
                        kind_next = chsd_pkg::KIND_ARCHIVE_END;
                        fb.act    = chsd_pkg::ACT_DONE;
                    end
                    else if (is_ctrl)
                    begin
                        fb.act = chsd_pkg::ACT_HALT;
                    end
                    else
                    begin
                        kind_next = chsd_pkg::KIND_CONTENT_BYTE;
                    end
                end
                if (fb.act == chsd_pkg::ACT_HALT)
                begin
                    sym_next  = '0;
                    kind_next = chsd_pkg::KIND_ERROR;
                    err_next  = chsd_pkg::ERR_UNEXPECTED;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            content_reg   <= 1'b0;
            fe_reg        <= chsd_pkg::FILENAME_END_RST;
            mf_reg        <= chsd_pkg::MORE_FILES_RST;
            ae_reg        <= chsd_pkg::ARCHIVE_END_RST;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            content_reg   <= content_next;
            if (cfg_write_en)
            begin
                case (cfg_index)
                    chsd_pkg::CFG_FILENAME_END: fe_reg <= cfg_data;
                    chsd_pkg::CFG_MORE_FILES:   mf_reg <= cfg_data;
                    chsd_pkg::CFG_ARCHIVE_END:  ae_reg <= cfg_data;
                    default:                    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg  <= sym_next;
        kind_reg <= kind_next;
        err_reg  <= err_next;
        if (cmd_pop && !is_write)
        begin
            s1_lookup_reg <= (cmd.op == chsd_pkg::OP_LOOKUP);
            s1_err_reg    <= cmd.err;
        end
    end

    // symbol memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd_pop && is_write)
        begin
            mem[cmd.addr] <= cmd.data;
        end
        if (cmd_pop && (cmd.op == chsd_pkg::OP_LOOKUP))
        begin
            rd_data_reg <= mem[cmd.addr];
        end
    end
endmodule
`default_nettype wire
